### rtl/rucrw_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle update command ring writer: shared package
// Types and constants shared by the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rucrw_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CurW    = 21;
  localparam int unsigned OffW    = 20;
  localparam int unsigned WordW   = 32;
  localparam int unsigned PixW    = 11;
  localparam int unsigned StatW   = 3;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCR_WIDTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCR_HEIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RING_START = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RING_END   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAPPED     = 3'd5;

  // Result status codes.
  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_DISABLED = 3'd1;
  localparam logic [StatW-1:0] ST_EMPTY    = 3'd2;
  localparam logic [StatW-1:0] ST_BOUNDS   = 3'd3;
  localparam logic [StatW-1:0] ST_FULL     = 3'd4;

  // Command and ring constants.
  localparam logic [WordW-1:0] OP_UPDATE    = 32'd1;
  localparam logic [CurW-1:0]  HEADER_BYTES = 21'd16;
  localparam logic [CurW-1:0]  WORD_BYTES   = 21'd4;
  localparam logic [PixW-1:0]  MODE_W_MAX   = 11'd1920;
  localparam logic [PixW-1:0]  MODE_H_MAX   = 11'd1200;

  // Word steps of one update command: opcode, x, y, w, h, then the final status.
  localparam logic [2:0] STEP_OP    = 3'd0;
  localparam logic [2:0] STEP_X     = 3'd1;
  localparam logic [2:0] STEP_Y     = 3'd2;
  localparam logic [2:0] STEP_W     = 3'd3;
  localparam logic [2:0] STEP_FINAL = 3'd5;

  // Kinds of work handed from the front end to the back end.
  typedef enum logic [1:0] {
    JOB_FINAL  = 2'd0,  // a single final result with a fixed status
    JOB_CURSOR = 2'd1,  // host read cursor update
    JOB_RECT   = 2'd2   // clamped rectangle to be written into the ring
  } job_kind_e;

  typedef struct packed {
    job_kind_e             kind;
    logic [StatW-1:0]      status;
    logic [PixW-1:0]       x;
    logic [PixW-1:0]       y;
    logic [PixW-1:0]       w;
    logic [PixW-1:0]       h;
    logic [CurW-1:0]       cursor;
  } job_t;

  typedef struct packed {
    logic                  enable;
    logic [PixW-1:0]       screen_width;
    logic [PixW-1:0]       screen_height;
    logic [CurW-1:0]       ring_start;
    logic [CurW-1:0]       ring_end;
    logic [CurW-1:0]       mapped_bytes;
  } cfg_t;

  typedef struct packed {
    logic                  write_enable;
    logic [OffW-1:0]       write_offset;
    logic [WordW-1:0]      write_word;
    logic [CurW-1:0]       new_cursor;
    logic                  sync_request;
    logic [StatW-1:0]      status;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

### rtl/rucrw_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying present-rectangle and read-cursor requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface rucrw_req_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] rect_x;
  logic signed [COORD_BITS-1:0] rect_y;
  logic signed [COORD_BITS-1:0] rect_w;
  logic signed [COORD_BITS-1:0] rect_h;
  logic [rucrw_pkg::CurW-1:0]   read_cursor;

  modport source (
    output valid, func, rect_x, rect_y, rect_w, rect_h, read_cursor,
    input  ready
  );

  modport sink (
    input  valid, func, rect_x, rect_y, rect_w, rect_h, read_cursor,
    output ready
  );
endinterface

`default_nettype wire

### rtl/rucrw_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying ring word writes and final status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rucrw_res_if;
  logic                         valid;
  logic                         ready;
  logic                         write_enable;
  logic [rucrw_pkg::OffW-1:0]   write_offset;
  logic [rucrw_pkg::WordW-1:0]  write_word;
  logic [rucrw_pkg::CurW-1:0]   new_cursor;
  logic                         sync_request;
  logic [rucrw_pkg::StatW-1:0]  status;
  logic                         last;

  modport source (
    output valid, write_enable, write_offset, write_word, new_cursor,
           sync_request, status, last,
    input  ready
  );

  modport sink (
    input  valid, write_enable, write_offset, write_word, new_cursor,
           sync_request, status, last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/rucrw_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts requests, clamps rectangles to the screen and classifies each
// request into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rucrw_front #(
  parameter int unsigned COORD_BITS = 16
) (
  rucrw_req_if.sink          req_if,
  input  rucrw_pkg::cfg_t    cfg_i,
  input  logic               q_full_i,
  output logic               push_o,
  output rucrw_pkg::job_t    job_o
);

  // Two guard bits cover the sum of a shrunk size and the origin.
  localparam int unsigned CW = COORD_BITS + 2;

  logic [rucrw_pkg::PixW-1:0] sw;
  logic [rucrw_pkg::PixW-1:0] sh;
  logic signed [CW-1:0]       sw_s;
  logic signed [CW-1:0]       sh_s;
  logic signed [CW-1:0]       x_in;
  logic signed [CW-1:0]       y_in;
  logic signed [CW-1:0]       w_in;
  logic signed [CW-1:0]       h_in;
  logic signed [CW-1:0]       x_c;
  logic signed [CW-1:0]       y_c;
  logic signed [CW-1:0]       w_c;
  logic signed [CW-1:0]       h_c;
  logic signed [CW-1:0]       w_f;
  logic signed [CW-1:0]       h_f;
  logic                       off_screen;
  logic                       no_area;

  // A request is taken whenever the queue has room.
  assign req_if.ready = !q_full_i;
  assign push_o       = req_if.valid && !q_full_i;

  // Oversized modes saturate at the largest supported screen.
  assign sw   = (cfg_i.screen_width  > rucrw_pkg::MODE_W_MAX) ? rucrw_pkg::MODE_W_MAX
                                                              : cfg_i.screen_width;
  assign sh   = (cfg_i.screen_height > rucrw_pkg::MODE_H_MAX) ? rucrw_pkg::MODE_H_MAX
                                                              : cfg_i.screen_height;
  assign sw_s = CW'(sw);
  assign sh_s = CW'(sh);

  assign x_in = CW'(req_if.rect_x);
  assign y_in = CW'(req_if.rect_y);
  assign w_in = CW'(req_if.rect_w);
  assign h_in = CW'(req_if.rect_h);

  // A negative origin moves to zero and shrinks the size by the same amount.
  always_comb begin
    x_c = x_in;
    w_c = w_in;
    y_c = y_in;
    h_c = h_in;
    if (x_in < 0) begin
      w_c = w_in + x_in;
      x_c = '0;
    end
    if (y_in < 0) begin
      h_c = h_in + y_in;
      y_c = '0;
    end
  end

  // Overhang past the right or bottom edge is cut at the edge.
  assign off_screen = (x_c >= sw_s) || (y_c >= sh_s);
  assign w_f        = (x_c + w_c > sw_s) ? (sw_s - x_c) : w_c;
  assign h_f        = (y_c + h_c > sh_s) ? (sh_s - y_c) : h_c;
  assign no_area    = (w_f <= 0) || (h_f <= 0);

  // Classification into a job.
  always_comb begin
    job_o.kind   = rucrw_pkg::JOB_FINAL;
    job_o.status = rucrw_pkg::ST_OK;
    job_o.x      = x_c[rucrw_pkg::PixW-1:0];
    job_o.y      = y_c[rucrw_pkg::PixW-1:0];
    job_o.w      = w_f[rucrw_pkg::PixW-1:0];
    job_o.h      = h_f[rucrw_pkg::PixW-1:0];
    job_o.cursor = req_if.read_cursor;
    if (req_if.func) begin
      job_o.kind = rucrw_pkg::JOB_CURSOR;
    end else if (!cfg_i.enable) begin
      job_o.status = rucrw_pkg::ST_DISABLED;
    end else if (off_screen || no_area) begin
      job_o.status = rucrw_pkg::ST_EMPTY;
    end else begin
      job_o.kind = rucrw_pkg::JOB_RECT;
    end
  end

endmodule

`default_nettype wire

### rtl/rucrw_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Two-entry first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rucrw_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rucrw_pkg::job_t    job_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output rucrw_pkg::job_t    job_o
);

  rucrw_pkg::job_t entry_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;
  logic            do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

### rtl/rucrw_back.sv
// ----------------------------------------------------------------------------
// Back end
// Carries out queued jobs: writes the update command into the ring word by
// word, keeps the write and host cursors and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rucrw_back #(
  parameter int unsigned RING_BYTES_MAX = 1048576
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rucrw_pkg::cfg_t    cfg_i,
  input  logic               job_valid_i,
  input  rucrw_pkg::job_t    job_i,
  output logic               pop_o,
  rucrw_res_if.source        res_if
);

  localparam int unsigned CapW = 25;
  localparam logic [CapW-1:0] RingMax = CapW'(RING_BYTES_MAX);

  logic [rucrw_pkg::CurW-1:0]  cap;
  logic [rucrw_pkg::CurW-1:0]  hi_d;
  logic [rucrw_pkg::CurW-1:0]  hi_q;
  logic                        cfg_bad_d;
  logic                        cfg_bad_q;
  logic [rucrw_pkg::CurW-1:0]  wc_d;
  logic [rucrw_pkg::CurW-1:0]  wc_q;
  logic [rucrw_pkg::CurW-1:0]  hc_d;
  logic [rucrw_pkg::CurW-1:0]  hc_q;
  logic [2:0]                  step_d;
  logic [2:0]                  step_q;
  logic [rucrw_pkg::CurW:0]    nxt_sum;
  logic [rucrw_pkg::CurW-1:0]  nxt;
  logic                        cur_bad;
  logic                        full;
  logic [rucrw_pkg::WordW-1:0] word;
  logic                        can_load;
  logic                        res_load;
  rucrw_pkg::result_t          res_d;
  rucrw_pkg::result_t          res_q;
  logic                        out_valid_q;

  // Effective ring end and bounds check, registered from the configuration.
  assign cap  = (cfg_i.ring_end > cfg_i.mapped_bytes) ? cfg_i.mapped_bytes : cfg_i.ring_end;
  assign hi_d = (CapW'(cap) > RingMax) ? rucrw_pkg::CurW'(RingMax) : cap;
  assign cfg_bad_d = (cfg_i.ring_start < rucrw_pkg::HEADER_BYTES) ||
                     (hi_d <= cfg_i.ring_start) ||
                     (hi_d[1:0] != 2'b00) ||
                     (cfg_i.ring_start[1:0] != 2'b00);

  always_ff @(posedge clk_i) begin
    hi_q      <= hi_d;
    cfg_bad_q <= cfg_bad_d;
  end

  // Cursor checks and the position after the current word.
  assign cur_bad = (wc_q < cfg_i.ring_start) || (wc_q >= hi_q) || (wc_q[1:0] != 2'b00);
  assign nxt_sum = {1'b0, wc_q} + {1'b0, rucrw_pkg::WORD_BYTES};
  assign nxt     = (nxt_sum >= {1'b0, hi_q}) ? cfg_i.ring_start
                                              : nxt_sum[rucrw_pkg::CurW-1:0];
  assign full    = (nxt == hc_q);

  // Word of the command for the current step.
  always_comb begin
    case (step_q)
      rucrw_pkg::STEP_OP: word = rucrw_pkg::OP_UPDATE;
      rucrw_pkg::STEP_X:  word = rucrw_pkg::WordW'(job_i.x);
      rucrw_pkg::STEP_Y:  word = rucrw_pkg::WordW'(job_i.y);
      rucrw_pkg::STEP_W:  word = rucrw_pkg::WordW'(job_i.w);
      default:            word = rucrw_pkg::WordW'(job_i.h);
    endcase
  end

  // The result register takes a new result when empty or being drained.
  assign can_load = !out_valid_q || res_if.ready;

  // Job execution: one result per cycle while the result register can take one.
  always_comb begin
    pop_o              = 1'b0;
    res_load           = 1'b0;
    step_d             = step_q;
    wc_d               = wc_q;
    hc_d               = hc_q;
    res_d.write_enable = 1'b0;
    res_d.write_offset = '0;
    res_d.write_word   = '0;
    res_d.sync_request = 1'b0;
    res_d.status       = rucrw_pkg::ST_OK;
    res_d.last         = 1'b1;
    if (job_valid_i && can_load) begin
      res_load = 1'b1;
      unique case (job_i.kind)
        rucrw_pkg::JOB_CURSOR: begin
          hc_d  = job_i.cursor;
          pop_o = 1'b1;
        end
        rucrw_pkg::JOB_RECT: begin
          if (step_q == rucrw_pkg::STEP_FINAL) begin
            res_d.sync_request = 1'b1;
            pop_o              = 1'b1;
            step_d             = '0;
          end else if (cfg_bad_q || cur_bad) begin
            res_d.status = rucrw_pkg::ST_BOUNDS;
            pop_o        = 1'b1;
            step_d       = '0;
          end else if (full) begin
            res_d.status       = rucrw_pkg::ST_FULL;
            res_d.sync_request = 1'b1;
            pop_o              = 1'b1;
            step_d             = '0;
          end else begin
            res_d.write_enable = 1'b1;
            res_d.write_offset = wc_q[rucrw_pkg::OffW-1:0];
            res_d.write_word   = word;
            res_d.last         = 1'b0;
            wc_d               = nxt;
            step_d             = step_q + 3'd1;
          end
        end
        default: begin
          res_d.status = job_i.status;
          pop_o        = 1'b1;
        end
      endcase
    end
    res_d.new_cursor = wc_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      wc_q        <= rucrw_pkg::HEADER_BYTES;
      hc_q        <= rucrw_pkg::HEADER_BYTES;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      wc_q   <= wc_d;
      hc_q   <= hc_d;
      if (can_load) begin
        out_valid_q <= res_load;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_if.valid        = out_valid_q;
  assign res_if.write_enable = res_q.write_enable;
  assign res_if.write_offset = res_q.write_offset;
  assign res_if.write_word   = res_q.write_word;
  assign res_if.new_cursor   = res_q.new_cursor;
  assign res_if.sync_request = res_q.sync_request;
  assign res_if.status       = res_q.status;
  assign res_if.last         = res_q.last;

endmodule

`default_nettype wire

### rtl/rect_update_command_ring_writer_unit.sv
// ----------------------------------------------------------------------------
// Rectangle update command ring writer
// Clamps present rectangles to the screen and writes update commands into a
// byte-addressed command ring; also tracks the host read cursor.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries requests: func 0 presents a rectangle, func 1 sets the host
//   read cursor. res_if returns one result per cycle while the receiver is
//   ready: up to five ring word writes (opcode, x, y, w, h) and then a final
//   result with last set, the status and the sync request. Read cursor,
//   disabled and empty requests give the final result alone. Configuration is
//   written through cfg_we_i, cfg_index_i and cfg_data_i; the user must do so
//   only while the block is idle, as the block does not enforce it. A request
//   is registered in the queue, then in the result register. A full update
//   command gives six results, one per cycle while the receiver is ready; other
//   requests give one. The front end keeps taking requests into a two-entry
//   queue while the back end works or the receiver stalls; a stalled receiver
//   holds the result register and, once the queue fills, request ready drops.
//   Reset empties the queue and the result register, sets both cursors to the
//   ring start of sixteen and loads the configuration reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_update_command_ring_writer_unit #(
  parameter int unsigned RING_BYTES_MAX = 1048576,
  parameter int unsigned COORD_BITS     = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rucrw_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rucrw_pkg::CurW-1:0]        cfg_data_i,
  rucrw_req_if.sink                         req_if,
  rucrw_res_if.source                       res_if
);

  rucrw_pkg::cfg_t cfg_q;
  rucrw_pkg::job_t front_job;
  rucrw_pkg::job_t head_job;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b0;
      cfg_q.screen_width  <= 11'd1024;
      cfg_q.screen_height <= 11'd768;
      cfg_q.ring_start    <= 21'd16;
      cfg_q.ring_end      <= 21'd65536;
      cfg_q.mapped_bytes  <= 21'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rucrw_pkg::CFG_ENABLE:     cfg_q.enable        <= cfg_data_i[0];
        rucrw_pkg::CFG_SCR_WIDTH:  cfg_q.screen_width  <= cfg_data_i[rucrw_pkg::PixW-1:0];
        rucrw_pkg::CFG_SCR_HEIGHT: cfg_q.screen_height <= cfg_data_i[rucrw_pkg::PixW-1:0];
        rucrw_pkg::CFG_RING_START: cfg_q.ring_start    <= cfg_data_i;
        rucrw_pkg::CFG_RING_END:   cfg_q.ring_end      <= cfg_data_i;
        rucrw_pkg::CFG_MAPPED:     cfg_q.mapped_bytes  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: accept and classify.
  rucrw_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .req_if   (req_if),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (front_job)
  );

  // Queue between the two halves.
  rucrw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // Back end: ring writes and results.
  rucrw_back #(
    .RING_BYTES_MAX (RING_BYTES_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .res_if      (res_if)
  );

endmodule

`default_nettype wire
